// ===== src/fbpa_pkg.sv =====
// Shared constants for the fixed block pool allocator.
// Field widths, mode and status codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int MODE_W   = 2;
  localparam int OFFSET_W = 20;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 13;
  localparam int COUNT_W  = 9;
  localparam int LINK_W   = 8;
  localparam int ALLOC_W  = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CNT_W  = 3;

  localparam int DEF_MAX_BLOCKS = 256;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REINIT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISALIGN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd16;
  localparam logic [SIZE_W-1:0]  SIZE_MAX    = 13'd4096;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

// ===== src/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: free list of equal blocks in a link memory.
// Uses fbpa_pkg for widths, codes and reset values.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | in_mode, in_offset
//  out     | output    | out_valid / out_stall | status, offset, free count, flags
//  cfg     | input     | cfg_we                | cfg_index, cfg_wdata
//
// Allocate, reinit, no-op and out-of-range free: S_EXEC after accept, then out_valid in S_OUT.
// In-range free: S_EXEC, the 8-step restoring divider in S_DIV, S_FIN, then out_valid in S_OUT.
// Ready again the cycle after the result is taken; only one item is in flight at a time.
// Link entries carry valid bits cleared at once by reset, reinit or a count write.
// out_stall holds the result; in_stall stays high until it is taken.
`timescale 1ns / 1ps

module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fbpa_pkg::MODE_W-1:0]     in_mode,
  input  logic [fbpa_pkg::OFFSET_W-1:0]   in_offset,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fbpa_pkg::STATUS_W-1:0]   out_status,
  output logic [fbpa_pkg::OFFSET_W-1:0]   out_block_offset,
  output logic [fbpa_pkg::COUNT_W-1:0]    out_free_blocks,
  output logic                            out_all_free,
  output logic [fbpa_pkg::ALLOC_W-1:0]    out_allocations,
  input  logic                            cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [fbpa_pkg::COUNT_W-1:0] MAXB = MAX_BLOCKS[fbpa_pkg::COUNT_W-1:0];
  localparam int SIZE_W  = fbpa_pkg::SIZE_W;
  localparam int COUNT_W = fbpa_pkg::COUNT_W;
  localparam int LINK_W  = fbpa_pkg::LINK_W;
  localparam int OFF_W   = fbpa_pkg::OFFSET_W;

  fbpa_pkg::state_t state_r, state_nxt;

  logic [SIZE_W-1:0]          size_r, size_nxt;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic [LINK_W-1:0]          head_r, head_nxt;
  logic [COUNT_W-1:0]         free_r, free_nxt;
  logic [fbpa_pkg::ALLOC_W-1:0] alloc_r, alloc_nxt;
  logic [MAX_BLOCKS-1:0]      vld_r, vld_nxt;

  logic [fbpa_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [OFF_W-1:0]           rem_r, rem_nxt;
  logic [OFF_W-1:0]           dv_r, dv_nxt;
  logic [LINK_W-1:0]          q_r, q_nxt;
  logic [fbpa_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [fbpa_pkg::STATUS_W-1:0] st_r, st_nxt;
  logic [OFF_W-1:0]           boff_r, boff_nxt;

  logic [LINK_W-1:0] mem [MAX_BLOCKS];
  logic [LINK_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;

  logic [SIZE_W-1:0]  size_eff;
  logic [COUNT_W-1:0] count_eff;
  logic [COUNT_W-1:0] cfg_count_eff;
  logic [SIZE_W+LINK_W-1:0]  prod_alloc;
  logic [SIZE_W+COUNT_W-1:0] prod_limit;
  logic              div_ge;

  always_comb begin
    if (size_r == '0) size_eff = SIZE_W'(1);
    else if (size_r > fbpa_pkg::SIZE_MAX) size_eff = fbpa_pkg::SIZE_MAX;
    else size_eff = size_r;
  end

  always_comb begin
    if (count_r == '0) count_eff = COUNT_W'(1);
    else if (count_r > MAXB) count_eff = MAXB;
    else count_eff = count_r;
  end

  always_comb begin
    if (cfg_wdata[COUNT_W-1:0] == '0) cfg_count_eff = COUNT_W'(1);
    else if (cfg_wdata[COUNT_W-1:0] > MAXB) cfg_count_eff = MAXB;
    else cfg_count_eff = cfg_wdata[COUNT_W-1:0];
  end

  assign prod_alloc = head_r * size_eff;
  assign prod_limit = count_eff * size_eff;
  assign div_ge     = rem_r >= dv_r;
  assign rd_addr    = ({1'b0, head_r} < MAXB) ? head_r[AW-1:0] : '0;
  assign mem_wa     = q_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    free_nxt  = free_r;
    alloc_nxt = alloc_r;
    vld_nxt   = vld_r;
    mode_nxt  = mode_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    boff_nxt  = boff_r;
    mem_we    = 1'b0;

    case (state_r)
      fbpa_pkg::S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          rem_nxt   = in_offset;
          state_nxt = fbpa_pkg::S_EXEC;
        end
      end
      fbpa_pkg::S_EXEC: begin
        st_nxt    = fbpa_pkg::ST_OK;
        boff_nxt  = '0;
        state_nxt = fbpa_pkg::S_OUT;
        case (mode_r)
          fbpa_pkg::MODE_ALLOC: begin
            if (free_r == '0) begin
              st_nxt = fbpa_pkg::ST_EMPTY;
            end else begin
              boff_nxt  = prod_alloc[OFF_W-1:0];
              head_nxt  = rd_vld_r ? rd_data_r : head_r + LINK_W'(1);
              free_nxt  = free_r - COUNT_W'(1);
              alloc_nxt = alloc_r + 1'b1;
            end
          end
          fbpa_pkg::MODE_FREE: begin
            if ({2'b0, rem_r} >= prod_limit) begin
              st_nxt = fbpa_pkg::ST_RANGE;
            end else begin
              dv_nxt    = {size_eff, 7'b0};
              q_nxt     = '0;
              cnt_nxt   = fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS - 1);
              state_nxt = fbpa_pkg::S_DIV;
            end
          end
          fbpa_pkg::MODE_REINIT: begin
            vld_nxt  = '0;
            head_nxt = '0;
            free_nxt = count_eff;
          end
          default: begin
          end
        endcase
      end
      fbpa_pkg::S_DIV: begin
        if (div_ge) rem_nxt = rem_r - dv_r;
        q_nxt  = {q_r[LINK_W-2:0], div_ge};
        dv_nxt = dv_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = fbpa_pkg::S_FIN;
      end
      fbpa_pkg::S_FIN: begin
        state_nxt = fbpa_pkg::S_OUT;
        if (rem_r != '0) begin
          st_nxt = fbpa_pkg::ST_MISALIGN;
        end else begin
          mem_we          = 1'b1;
          vld_nxt[mem_wa] = 1'b1;
          head_nxt        = q_r;
          if (free_r < count_eff) free_nxt = free_r + COUNT_W'(1);
        end
      end
      fbpa_pkg::S_OUT: begin
        if (!out_stall) state_nxt = fbpa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fbpa_pkg::S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        fbpa_pkg::REG_BLOCK_SIZE: begin
          size_nxt = cfg_wdata[SIZE_W-1:0];
        end
        fbpa_pkg::REG_BLOCK_COUNT: begin
          count_nxt = cfg_wdata[COUNT_W-1:0];
          vld_nxt   = '0;
          head_nxt  = '0;
          free_nxt  = cfg_count_eff;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbpa_pkg::S_IDLE;
      size_r  <= fbpa_pkg::SIZE_RESET;
      count_r <= fbpa_pkg::COUNT_RESET;
      head_r  <= '0;
      free_r  <= MAXB;
      alloc_r <= '0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      alloc_r <= alloc_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    rem_r  <= rem_nxt;
    dv_r   <= dv_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    st_r   <= st_nxt;
    boff_r <= boff_nxt;
  end

  // link memory, registered read at the current head
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= head_r;
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  assign in_stall         = (state_r != fbpa_pkg::S_IDLE);
  assign out_valid        = (state_r == fbpa_pkg::S_OUT);
  assign out_status       = st_r;
  assign out_block_offset = boff_r;
  assign out_free_blocks  = free_r;
  assign out_all_free     = (free_r >= count_eff);
  assign out_allocations  = alloc_r;

  a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("ready while a result is pending");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= MAXB)
    else $error("free count above pool size");

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != fbpa_pkg::ST_OK) |-> (out_block_offset == '0))
    else $error("failed item reports an offset");

  a_push_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ({1'b0, q_r} < count_eff))
    else $error("free pushes a block outside the pool");

endmodule
